[rtl/spm_pkg.sv]
// spm_pkg: shared constants, widths and types of the substitution pseudocount mixer
// no dependencies
package spm_pkg;

  localparam int MAX_ALPHABET = 32;
  localparam int FRAC_BITS    = 16;

  localparam int IDX_W  = $clog2(MAX_ALPHABET);
  localparam int CNT_W  = IDX_W + 1;
  localparam int VAL_W  = 16;
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = MAX_ALPHABET * MAX_ALPHABET;
  localparam int F_W    = FRAC_BITS + 1;
  localparam int ACC_W  = VAL_W + F_W + IDX_W;
  localparam int S_W    = ACC_W - FRAC_BITS;
  localparam int P1_W   = 2 * F_W;
  localparam int P2_W   = VAL_W + S_W;
  localparam int SUM_W  = ((P1_W > P2_W) ? P1_W : P2_W) + 1;
  localparam int M_W    = SUM_W - FRAC_BITS;
  localparam int T_W    = M_W + IDX_W;
  localparam int N_W    = M_W + FRAC_BITS + 1;
  localparam int Q_W    = FRAC_BITS + 1;
  localparam int QCNT_W = $clog2(Q_W + 1);

  localparam logic [F_W-1:0]   ONE_VAL   = F_W'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0] ALPHA_RST = CNT_W'(20);
  localparam logic [CNT_W-1:0] ALPHA_MAX = CNT_W'(MAX_ALPHABET);

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_COLUMN  = 2'd1,
    ACT_RESIDUE = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

[rtl/spm_if.sv]
// spm_in_if / spm_out_if: valid-ready channels of the mixer
// depends on spm_pkg
interface spm_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   action;
  logic [spm_pkg::IDX_W-1:0]    row_index;
  logic [spm_pkg::IDX_W-1:0]    col_index;
  logic [spm_pkg::VAL_W-1:0]    value;
  logic [spm_pkg::VAL_W-1:0]    mix_weight;
  logic [spm_pkg::IDX_W-1:0]    residue;
  logic                         last_element;

  modport source (output valid, action, row_index, col_index, value, mix_weight, residue,
                  last_element, input ready);
  modport sink   (input valid, action, row_index, col_index, value, mix_weight, residue,
                  last_element, output ready);
endinterface

interface spm_out_if;
  logic                      valid;
  logic                      ready;
  logic [spm_pkg::IDX_W-1:0] letter;
  logic [spm_pkg::VAL_W-1:0] frequency;
  logic                      last_of_column;

  modport source (output valid, letter, frequency, last_of_column, input ready);
  modport sink   (input valid, letter, frequency, last_of_column, output ready);
endinterface

[rtl/spm_ram.sv]
// spm_ram: generic single write / single read RAM with registered read
// no dependencies
module spm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/spm_cell.sv]
// spm_cell: one column cell, holds one frequency and passes it to its neighbor on shift
// depends on spm_pkg
module spm_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  spm_pkg::cell_ctl_t      ctl,
  input  logic                    load_en,
  input  logic [spm_pkg::F_W-1:0] load_val,
  input  logic [spm_pkg::F_W-1:0] shift_in,
  output logic [spm_pkg::F_W-1:0] val
);
  logic [spm_pkg::F_W-1:0] val_r, val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctl.clear) begin
      val_nxt = '0;
    end else if (ctl.shift) begin
      val_nxt = shift_in;
    end else if (load_en) begin
      val_nxt = load_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;
endmodule

[rtl/spm_div.sv]
// spm_div: restoring divider, one quotient bit per cycle, for the normalization
// depends on spm_pkg
module spm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [spm_pkg::N_W-1:0]    num,
  input  logic [spm_pkg::T_W-1:0]    den,
  output logic                       done,
  output logic [spm_pkg::Q_W-1:0]    quot
);
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [spm_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [spm_pkg::T_W-1:0]     rem_r, rem_nxt;
  logic [spm_pkg::Q_W-1:0]     lo_r, lo_nxt;
  logic [spm_pkg::Q_W-1:0]     q_r, q_nxt;
  logic [spm_pkg::T_W:0]       rem2;
  logic                        ge;

  assign rem2 = {rem_r, lo_r[spm_pkg::Q_W-1]};
  assign ge   = rem2 >= {1'b0, den};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = spm_pkg::QCNT_W'(spm_pkg::Q_W);
      // quotient fits Q_W bits, so the high part is already below den
      rem_nxt  = spm_pkg::T_W'(num[spm_pkg::N_W-1:spm_pkg::Q_W]);
      lo_nxt   = num[spm_pkg::Q_W-1:0];
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? spm_pkg::T_W'(rem2 - {1'b0, den}) : spm_pkg::T_W'(rem2);
      lo_nxt  = {lo_r[spm_pkg::Q_W-2:0], 1'b0};
      q_nxt   = {q_r[spm_pkg::Q_W-2:0], ge};
      cnt_nxt = cnt_r - spm_pkg::QCNT_W'(1);
      if (cnt_r == spm_pkg::QCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

[rtl/substitution_pseudocount_mixer.sv]
// substitution_pseudocount_mixer: top level, sequencer, table RAM, cell ring and mixing
// depends on spm_pkg, spm_if, spm_ram, spm_cell, spm_div
// a table load or a non-last element is only stored; a column or residue item runs a
//   multiply-accumulate per row (one table entry per cycle off the RAM read port,
//   a full turn of the 32-cell ring per row), then one divider run per result
// throughput: one item at a time, input ready only when the previous results are all taken
// reset: synchronous active-low; clears control, the column cells and sets alphabet size 20
module substitution_pseudocount_mixer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [spm_pkg::CNT_W-1:0]  cfg_data,
  spm_in_if.sink                     in_ch,
  spm_out_if.source                  out_ch
);
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ROW    = 7'b0000010,
    S_MIX1   = 7'b0000100,
    S_MIX2   = 7'b0001000,
    S_DSTART = 7'b0010000,
    S_DWAIT  = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [spm_pkg::CNT_W-1:0]     n_r, n_nxt;
  logic [spm_pkg::CNT_W-1:0]     a_r, a_nxt;
  logic [spm_pkg::CNT_W-1:0]     b_r, b_nxt;
  logic                          resmode_r, resmode_nxt;
  logic [spm_pkg::IDX_W-1:0]     res_r, res_nxt;
  logic [spm_pkg::VAL_W-1:0]     tau_r, tau_nxt;
  logic [spm_pkg::F_W-1:0]       fq_r, fq_nxt;
  logic                          vq_r, vq_nxt;
  logic [spm_pkg::F_W-1:0]       fa_r, fa_nxt;
  logic [spm_pkg::ACC_W-1:0]     acc_r, acc_nxt;
  logic [spm_pkg::P1_W-1:0]      p1_r, p1_nxt;
  logic [spm_pkg::T_W-1:0]       tot_r, tot_nxt;
  logic [spm_pkg::Q_W-1:0]       q_r, q_nxt;
  logic [spm_pkg::M_W-1:0]       mix_r [spm_pkg::MAX_ALPHABET];

  logic                          in_acc;
  spm_pkg::action_t              act;
  logic                          ram_we;
  logic [spm_pkg::ADDR_W-1:0]    raddr;
  logic [spm_pkg::VAL_W-1:0]     rdata;
  logic [spm_pkg::F_W-1:0]       cell_val [spm_pkg::MAX_ALPHABET];
  spm_pkg::cell_ctl_t            cell_ctl;
  logic [spm_pkg::F_W-1:0]       f_cur;
  logic [spm_pkg::SUM_W-1:0]     mix_sum;
  logic [spm_pkg::M_W-1:0]       m_new;
  logic                          mix_we;
  logic                          div_start, div_done;
  logic [spm_pkg::Q_W-1:0]       div_q;
  logic [spm_pkg::N_W-1:0]       div_num;
  logic                          last_letter;

  function automatic logic [spm_pkg::M_W:0] m_sel_ext(input logic [spm_pkg::M_W-1:0] m);
    m_sel_ext = {1'b0, m};
  endfunction

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign act         = spm_pkg::action_t'(in_ch.action);
  assign ram_we      = in_acc && (act == spm_pkg::ACT_LOAD);
  assign raddr       = {a_r[spm_pkg::IDX_W-1:0], b_r[spm_pkg::IDX_W-1:0]};
  assign last_letter = (a_r == n_r - spm_pkg::CNT_W'(1));

  spm_ram #(.WIDTH(spm_pkg::VAL_W), .DEPTH(spm_pkg::DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({in_ch.row_index, in_ch.col_index}),
    .wdata (in_ch.value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // ring of cells, rotated by one position per cycle during a row sweep
  for (genvar i = 0; i < spm_pkg::MAX_ALPHABET; i++) begin : g_cell
    localparam int NEXT = (i + 1) % spm_pkg::MAX_ALPHABET;
    spm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cell_ctl),
      .load_en  (in_acc && (act == spm_pkg::ACT_COLUMN) &&
                 (in_ch.row_index == spm_pkg::IDX_W'(i)) &&
                 ({1'b0, in_ch.row_index} < n_r)),
      .load_val ({1'b0, in_ch.value}),
      .shift_in (cell_val[NEXT]),
      .val      (cell_val[i])
    );
  end

  assign div_num = {m_sel_ext(mix_r[a_r[spm_pkg::IDX_W-1:0]]), {spm_pkg::FRAC_BITS{1'b0}}} +
                   spm_pkg::N_W'(tot_r >> 1);

  spm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (tot_r),
    .done  (div_done),
    .quot  (div_q)
  );

  always_comb begin
    if (resmode_r) begin
      f_cur = (b_r[spm_pkg::IDX_W-1:0] == res_r) ? spm_pkg::ONE_VAL : '0;
    end else begin
      f_cur = cell_val[0];
    end
    mix_sum = spm_pkg::SUM_W'(p1_r) +
              spm_pkg::SUM_W'(tau_r * acc_r[spm_pkg::ACC_W-1:spm_pkg::FRAC_BITS]);
    m_new   = mix_sum[spm_pkg::SUM_W-1:spm_pkg::FRAC_BITS];
  end

  always_comb begin
    state_nxt   = state_r;
    n_nxt       = n_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    resmode_nxt = resmode_r;
    res_nxt     = res_r;
    tau_nxt     = tau_r;
    fq_nxt      = fq_r;
    vq_nxt      = vq_r;
    fa_nxt      = fa_r;
    acc_nxt     = acc_r;
    p1_nxt      = p1_r;
    tot_nxt     = tot_r;
    q_nxt       = q_r;
    cell_ctl    = '0;
    mix_we      = 1'b0;
    div_start   = 1'b0;

    if (cfg_we) begin
      if (cfg_data == '0) begin
        n_nxt = spm_pkg::CNT_W'(1);
      end else if (cfg_data > spm_pkg::ALPHA_MAX) begin
        n_nxt = spm_pkg::ALPHA_MAX;
      end else begin
        n_nxt = cfg_data;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          a_nxt   = '0;
          b_nxt   = '0;
          tot_nxt = '0;
          unique case (act)
            spm_pkg::ACT_COLUMN: begin
              tau_nxt     = in_ch.mix_weight;
              resmode_nxt = 1'b0;
              if (in_ch.last_element) begin
                state_nxt = S_ROW;
              end
            end
            spm_pkg::ACT_RESIDUE: begin
              tau_nxt     = in_ch.mix_weight;
              res_nxt     = in_ch.residue;
              resmode_nxt = 1'b1;
              state_nxt   = S_ROW;
            end
            default: begin
            end
          endcase
        end
      end
      S_ROW: begin
        if (b_r < spm_pkg::ALPHA_MAX) begin
          cell_ctl.shift = 1'b1;
          fq_nxt = f_cur;
          vq_nxt = (b_r < n_r);
          if (b_r == a_r) begin
            fa_nxt = f_cur;
          end
        end
        if (b_r == '0) begin
          acc_nxt = '0;
        end else if (vq_r) begin
          acc_nxt = acc_r + spm_pkg::ACC_W'(rdata * fq_r);
        end
        if (b_r == spm_pkg::ALPHA_MAX) begin
          state_nxt = S_MIX1;
        end else begin
          b_nxt = b_r + spm_pkg::CNT_W'(1);
        end
      end
      S_MIX1: begin
        p1_nxt    = spm_pkg::P1_W'((spm_pkg::ONE_VAL - {1'b0, tau_r}) * fa_r);
        state_nxt = S_MIX2;
      end
      S_MIX2: begin
        mix_we  = 1'b1;
        tot_nxt = tot_r + spm_pkg::T_W'(m_new);
        b_nxt   = '0;
        if (last_letter) begin
          a_nxt     = '0;
          state_nxt = S_DSTART;
        end else begin
          a_nxt     = a_r + spm_pkg::CNT_W'(1);
          state_nxt = S_ROW;
        end
      end
      S_DSTART: begin
        div_start = 1'b1;
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          // a column summing to zero gives zeros
          if (tot_r == '0) begin
            q_nxt = '0;
          end else begin
            q_nxt = div_q;
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ch.ready) begin
          if (last_letter) begin
            cell_ctl.clear = !resmode_r;
            state_nxt      = S_IDLE;
          end else begin
            a_nxt     = a_r + spm_pkg::CNT_W'(1);
            state_nxt = S_DSTART;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      n_r       <= spm_pkg::ALPHA_RST;
      a_r       <= '0;
      b_r       <= '0;
      resmode_r <= 1'b0;
      vq_r      <= 1'b0;
      tau_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      n_r       <= n_nxt;
      a_r       <= a_nxt;
      b_r       <= b_nxt;
      resmode_r <= resmode_nxt;
      vq_r      <= vq_nxt;
      tau_r     <= tau_nxt;
    end
    res_r  <= res_nxt;
    fq_r   <= fq_nxt;
    fa_r   <= fa_nxt;
    acc_r  <= acc_nxt;
    p1_r   <= p1_nxt;
    tot_r  <= tot_nxt;
    q_r    <= q_nxt;
    if (mix_we) begin
      mix_r[a_r[spm_pkg::IDX_W-1:0]] <= m_new;
    end
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = (state_r == S_OUT);
  assign out_ch.letter         = a_r[spm_pkg::IDX_W-1:0];
  assign out_ch.frequency      = q_r[spm_pkg::Q_W-1] ? {spm_pkg::VAL_W{1'b1}}
                                                     : q_r[spm_pkg::VAL_W-1:0];
  assign out_ch.last_of_column = (state_r == S_OUT) && last_letter;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("input taken while a result is pending");

  a_last_letter: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last_of_column) |->
      ({1'b0, out_ch.letter} == n_r - spm_pkg::CNT_W'(1)))
    else $error("column end flagged on wrong letter");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DWAIT))
    else $error("divider finished outside of wait state");

  a_div_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (state_r == S_DWAIT))
    else $error("divider launched without waiting");
endmodule

[bench/substitution_pseudocount_mixer_tb.sv]
// substitution_pseudocount_mixer_tb: self-checking bench that loads the substitution table, sends
// directed and random column, residue and table-load items and checks every emitted letter
// depends on spm_pkg, spm_if and the substitution_pseudocount_mixer rtl
`timescale 1ns / 1ps

module substitution_pseudocount_mixer_tb;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_WAIT = 60;
  localparam int HOLD_LEN   = 400;
  localparam int RAND_ITEMS = 460;

  typedef struct {
    spm_pkg::action_t act;
    logic [4:0]      row;
    logic [4:0]      col;
    logic [15:0]     value;
    logic [15:0]     tau;
    logic [4:0]      residue;
    logic            last;
    bit              zero_typed;
  } item_t;

  typedef struct {
    logic [4:0]  letter;
    logic [15:0] frequency;
    logic        last;
  } letter_freq_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [spm_pkg::CNT_W-1:0] cfg_data;

  spm_in_if  in_ch();
  spm_out_if out_ch();

  substitution_pseudocount_mixer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // mirror of the block state
  logic [15:0]      subst_tbl [32][32];
  logic [15:0]      col_freq [32];
  logic [15:0]      col_tau;
  logic [5:0]       alpha_reg;
  letter_freq_t     freq_q [$];

  int  mismatches;
  int  idle_cycles;
  bit  hold_req;
  item_t directed [$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int letters_in_use();
    int n;
    n = int'(alpha_reg);
    if (n < 1) n = 1;
    if (n > spm_pkg::MAX_ALPHABET) n = spm_pkg::MAX_ALPHABET;
    return n;
  endfunction

  function automatic void push_zero_column(int n);
    letter_freq_t e;
    for (int a = 0; a < n; a++) begin
      e.letter = a[4:0];
      e.frequency = '0;
      e.last = (a == n - 1);
      freq_q.push_back(e);
    end
  endfunction

  // mix f with the table-smoothed profile and normalize to one
  function automatic void mix_column(longint unsigned f[32], longint unsigned tau);
    int n;
    longint unsigned total, s, m, q;
    longint unsigned mixed [32];
    letter_freq_t e;
    n = letters_in_use();
    total = 0;
    if (tau > 64'd65536) tau = 64'd65536;
    for (int a = 0; a < n; a++) begin
      s = 0;
      for (int b = 0; b < n; b++) s += longint'(subst_tbl[a][b]) * f[b];
      s >>= spm_pkg::FRAC_BITS;
      m = ((64'd65536 - tau) * f[a] + tau * s) >> spm_pkg::FRAC_BITS;
      if (m > 64'hFFFF_FFFF) m = 64'hFFFF_FFFF;
      mixed[a] = m;
      total += m;
    end
    for (int a = 0; a < n; a++) begin
      q = 0;
      if (total != 0) begin
        q = ((mixed[a] << spm_pkg::FRAC_BITS) + total / 2) / total;
        if (q > 64'hFFFF) q = 64'hFFFF;
      end
      e.letter = a[4:0];
      e.frequency = q[15:0];
      e.last = (a == n - 1);
      freq_q.push_back(e);
    end
  endfunction

  function automatic void predict_item(item_t s);
    int n;
    longint unsigned f [32];
    n = letters_in_use();
    case (s.act)
      spm_pkg::ACT_LOAD: subst_tbl[s.row][s.col] = s.value;
      spm_pkg::ACT_COLUMN: begin
        col_tau = s.tau;
        if (s.row < n) col_freq[s.row] = s.value;
        if (s.last) begin
          for (int i = 0; i < 32; i++) f[i] = col_freq[i];
          if (s.zero_typed) push_zero_column(n);
          else mix_column(f, col_tau);
          for (int i = 0; i < 32; i++) col_freq[i] = '0;
        end
      end
      spm_pkg::ACT_RESIDUE: begin
        if (s.residue >= n || s.zero_typed) push_zero_column(n);
        else begin
          for (int i = 0; i < 32; i++) f[i] = 0;
          f[s.residue] = 64'd65536;
          mix_column(f, s.tau);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] rand_val();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom());
  endfunction

  function automatic item_t mk_item(spm_pkg::action_t act, int row, int col, int value,
                                    int tau, int residue, bit last, bit zero_typed);
    item_t s;
    s.act = act;
    s.row = row[4:0];
    s.col = col[4:0];
    s.value = value[15:0];
    s.tau = tau[15:0];
    s.residue = residue[4:0];
    s.last = last;
    s.zero_typed = zero_typed;
    return s;
  endfunction

  // called at a falling edge, returns at a falling edge after the transaction
  task automatic drive_item(item_t s);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= s.act;
    in_ch.row_index    <= s.row;
    in_ch.col_index    <= s.col;
    in_ch.value        <= s.value;
    in_ch.mix_weight   <= s.tau;
    in_ch.residue      <= s.residue;
    in_ch.last_element <= s.last;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(s);
    @(negedge clk);
  endtask

  task automatic write_alphabet(logic [5:0] n);
    in_ch.valid <= 1'b0;
    while (freq_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= n;
    @(negedge clk);
    cfg_we   <= 1'b0;
    alpha_reg = n;
  endtask

  task automatic random_items(int count);
    int sent, n, k, r;
    logic [15:0] tau;
    item_t s;
    sent = 0;
    while (sent < count) begin
      n = letters_in_use();
      r = $urandom_range(99);
      s = mk_item(spm_pkg::ACT_LOAD, 0, 0, 0, 0, 0, 1'b0, 1'b0);
      if (r < 12) begin
        s.row = 5'($urandom());
        s.col = 5'($urandom());
        s.value = rand_val();
        drive_item(s);
        sent++;
      end else if (r < 72) begin
        // one column, mostly well-formed, now and then a letter outside the alphabet
        k = $urandom_range(1, n + 2);
        tau = rand_val();
        for (int i = 0; i < k; i++) begin
          s.act = spm_pkg::ACT_COLUMN;
          s.row = ($urandom_range(9) == 0) ? 5'($urandom()) : 5'($urandom_range(n - 1));
          s.col = 5'($urandom());
          s.value = rand_val();
          s.tau = ($urandom_range(4) == 0) ? rand_val() : tau;
          s.residue = 5'($urandom());
          s.last = (i == k - 1);
          drive_item(s);
          sent++;
        end
      end else if (r < 94) begin
        s.act = spm_pkg::ACT_RESIDUE;
        s.residue = ($urandom_range(7) == 0) ? 5'($urandom()) : 5'($urandom_range(n - 1));
        s.tau = rand_val();
        s.row = 5'($urandom());
        s.value = 16'($urandom());
        s.last = 1'($urandom());
        drive_item(s);
        sent++;
      end else begin
        s.act = spm_pkg::ACT_NONE;
        s.row = 5'($urandom());
        s.value = 16'($urandom());
        s.tau = 16'($urandom());
        s.last = 1'($urandom());
        drive_item(s);
      end
    end
  endtask

  // result side: random stalls plus one long hold on request
  initial begin
    int g;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end else begin
        g = gap_len();
        if (g > 0) begin
          out_ch.ready <= 1'b0;
          repeat (g - 1) @(negedge clk);
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    letter_freq_t e;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (out_ch.valid && out_ch.ready) begin
        if (freq_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: letter %0d freq %h last %b",
                     out_ch.letter, out_ch.frequency, out_ch.last_of_column);
        end else begin
          e = freq_q.pop_front();
          if (out_ch.letter !== e.letter || out_ch.frequency !== e.frequency ||
              out_ch.last_of_column !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp letter %0d freq %h last %b, got letter %0d freq %h last %b",
                       e.letter, e.frequency, e.last,
                       out_ch.letter, out_ch.frequency, out_ch.last_of_column);
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL substitution_pseudocount_mixer");
        $finish;
      end
    end
  end

  initial begin
    logic [5:0] phases [7];
    mismatches = 0;
    idle_cycles = 0;
    hold_req = 1'b0;
    alpha_reg = 6'd20;
    col_tau = '0;
    for (int i = 0; i < 32; i++) col_freq[i] = '0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.action = spm_pkg::ACT_NONE;
    in_ch.row_index = '0;
    in_ch.col_index = '0;
    in_ch.value = '0;
    in_ch.mix_weight = '0;
    in_ch.residue = '0;
    in_ch.last_element = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // whole table first so no entry is read before it is written
    for (int a = 0; a < 32; a++)
      for (int b = 0; b < 32; b++)
        drive_item(mk_item(spm_pkg::ACT_LOAD, a, b, int'(rand_val()), 0, 0, 1'b0, 1'b0));

    // directed: n = 20 after reset
    directed.push_back(mk_item(spm_pkg::ACT_NONE, 3, 3, 16'hFFFF, 16'hFFFF, 3, 1'b1, 1'b0));
    // zero column
    directed.push_back(mk_item(spm_pkg::ACT_COLUMN, 3, 0, 0, 16'h4000, 0, 1'b1, 1'b1));
    // residue >= n
    directed.push_back(mk_item(spm_pkg::ACT_RESIDUE, 0, 0, 0, 16'h4000, 31, 1'b0, 1'b1));
    directed.push_back(mk_item(spm_pkg::ACT_RESIDUE, 0, 0, 0, 16'h4000, 20, 1'b0, 1'b1));
    directed.push_back(mk_item(spm_pkg::ACT_RESIDUE, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    directed.push_back(mk_item(spm_pkg::ACT_RESIDUE, 0, 0, 0, 16'hFFFF, 19, 1'b0, 1'b0));
    directed.push_back(mk_item(spm_pkg::ACT_LOAD, 0, 0, 16'hFFFF, 0, 0, 1'b0, 1'b0));
    directed.push_back(mk_item(spm_pkg::ACT_LOAD, 31, 31, 16'h0000, 0, 0, 1'b0, 1'b0));
    directed.push_back(mk_item(spm_pkg::ACT_COLUMN, 0, 0, 16'hFFFF, 16'h8000, 0, 1'b0, 1'b0));
    directed.push_back(mk_item(spm_pkg::ACT_COLUMN, 19, 0, 16'hFFFF, 16'h8000, 0, 1'b0, 1'b0));
    // letter outside the alphabet: stores nothing but closes the column
    directed.push_back(mk_item(spm_pkg::ACT_COLUMN, 25, 0, 16'h1234, 16'hFFFF, 0, 1'b1, 1'b0));
    directed.push_back(mk_item(spm_pkg::ACT_COLUMN, 7, 0, 16'h0001, 0, 0, 1'b1, 1'b0));
    directed.push_back(mk_item(spm_pkg::ACT_COLUMN, 31, 0, 16'hFFFF, 16'h0000, 0, 1'b1, 1'b1));
    for (int i = 0; i < 20; i++)
      directed.push_back(mk_item(spm_pkg::ACT_COLUMN, i, 0, 16'hFFFF, 16'hFFFF, 0, i == 19,
                                 1'b0));
    foreach (directed[i]) drive_item(directed[i]);

    phases = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd2, 6'($urandom_range(3, 31)), 6'd33};
    for (int p = 0; p < 7; p++) begin
      write_alphabet(phases[p]);
      if (p == 1) hold_req = 1'b1;
      random_items(RAND_ITEMS / 7);
    end

    in_ch.valid <= 1'b0;
    while (freq_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (mismatches == 0 && freq_q.size() == 0) begin
      $display("PASS substitution_pseudocount_mixer");
    end else begin
      $display("FAIL substitution_pseudocount_mixer");
    end
    $finish;
  end

endmodule

[files.f]
rtl/spm_pkg.sv
rtl/spm_if.sv
rtl/spm_ram.sv
rtl/spm_cell.sv
rtl/spm_div.sv
rtl/substitution_pseudocount_mixer.sv
bench/substitution_pseudocount_mixer_tb.sv
